FILE: rtl/core/chc_pkg.sv
// Shared constants, field widths and controller/datapath command and status
// structs for the canonical Huffman code assignment block. No dependencies.
`default_nettype none

package chc_pkg;

  localparam int ALPHABET_SIZE_DEF = 64;
  localparam int MAX_LENGTHS_DEF   = 16;

  localparam int LEN_W      = 4;
  localparam int IDX_W      = 6;
  localparam int CODE_OUT_W = 15;
  localparam int CODE_W     = 16;
  localparam int HIST_W     = 7;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic load_end;
    logic calc_done;
    logic emit_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/chc_ctrl.sv
// Sequencing state machine: load, first-code calculation, emit, drain.
// Depends on chc_pkg for the command and status structs.
`default_nettype none

module chc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire chc_pkg::sts_t sts,
  output chc_pkg::cmd_t      cmd
);
  import chc_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_CALC  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (sts.load_end) begin
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (sts.calc_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.clear = 1'b1;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chc_dpath.sv
// Datapath: length store, per-length histogram, first-code table and the
// bit-reversed code output stage. Depends on chc_pkg.
`default_nettype none

module chc_dpath #(
  parameter int ALPHABET_SIZE = chc_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_LENGTHS   = chc_pkg::MAX_LENGTHS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire chc_pkg::cmd_t                   cmd,
  output chc_pkg::sts_t                        sts,
  input  wire logic [chc_pkg::LEN_W-1:0]       in_code_length,
  input  wire logic                            in_last_symbol,
  output logic                                 out_strobe,
  output logic [chc_pkg::IDX_W-1:0]            out_symbol_index,
  output logic [chc_pkg::CODE_OUT_W-1:0]       out_code_bits,
  output logic [chc_pkg::LEN_W-1:0]            out_code_len,
  output logic                                 out_end_of_table
);
  import chc_pkg::*;

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int CW = $clog2(ALPHABET_SIZE + 1);
  localparam int HW = $clog2(MAX_LENGTHS);

  logic [LEN_W-1:0]      store_mem [ALPHABET_SIZE];
  logic [HIST_W-1:0]     hist_r    [MAX_LENGTHS];
  logic [CODE_W-1:0]     ntab_r    [MAX_LENGTHS];

  logic [CW-1:0]         count_r;
  logic [HW-1:0]         step_r;
  logic [CODE_W-1:0]     acc_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  rd_vld_r;
  logic [AW-1:0]         rd_sym_r;
  logic                  rd_last_r;
  logic [LEN_W-1:0]      rd_len_r;

  logic                  out_strobe_r;
  logic [IDX_W-1:0]      out_symbol_index_r;
  logic [CODE_OUT_W-1:0] out_code_bits_r;
  logic [LEN_W-1:0]      out_code_len_r;
  logic                  out_end_of_table_r;

  logic [HW-1:0]         len_sat;
  logic                  full;
  logic                  emit_last;
  logic [CODE_W-1:0]     acc_sum;
  logic [CODE_W-1:0]     acc_nxt;
  logic [HW-1:0]         cur_len;
  logic [CODE_W-1:0]     cur_code;
  logic [CODE_OUT_W-1:0] rev_code;

  always_comb begin
    if (in_code_length > LEN_W'(MAX_LENGTHS - 1)) begin
      len_sat = HW'(MAX_LENGTHS - 1);
    end else begin
      len_sat = in_code_length[HW-1:0];
    end
  end

  assign full      = (count_r == CW'(ALPHABET_SIZE - 1));
  assign emit_last = (CW'(rd_idx_r) == (count_r - CW'(1)));
  assign acc_sum   = acc_r + CODE_W'(hist_r[step_r - HW'(1)]);
  assign acc_nxt   = {acc_sum[CODE_W-2:0], 1'b0};
  assign cur_len   = rd_len_r[HW-1:0];
  assign cur_code  = ntab_r[cur_len];

  always_comb begin
    rev_code = '0;
    for (int j = 0; j < CODE_OUT_W; j++) begin
      if (j < int'(rd_len_r)) begin
        rev_code[j] = cur_code[4'(int'(rd_len_r) - 1 - j)];
      end
    end
  end

  assign sts.load_end  = in_last_symbol | full;
  assign sts.calc_done = (step_r == HW'(MAX_LENGTHS - 1));
  assign sts.emit_done = emit_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store_mem[count_r[AW-1:0]] <= LEN_W'(len_sat);
    end
    if (cmd.emit) begin
      rd_len_r <= store_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ntab_r[step_r] <= acc_nxt;
    end else if (rd_vld_r && (rd_len_r != '0)) begin
      ntab_r[cur_len] <= cur_code + CODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_LENGTHS; k++) begin
        hist_r[k] <= '0;
      end
    end else if (cmd.clear) begin
      for (int k = 0; k < MAX_LENGTHS; k++) begin
        hist_r[k] <= '0;
      end
    end else if (cmd.load && (len_sat != '0)) begin
      hist_r[len_sat] <= hist_r[len_sat] + HIST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      step_r       <= HW'(1);
      acc_r        <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.load) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.calc) begin
        step_r <= step_r + HW'(1);
        acc_r  <= acc_nxt;
      end else begin
        step_r <= HW'(1);
        acc_r  <= '0;
      end
      if (cmd.emit) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end else begin
        rd_idx_r <= '0;
      end
      rd_vld_r     <= cmd.emit;
      out_strobe_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_sym_r           <= rd_idx_r;
    rd_last_r          <= emit_last;
    out_symbol_index_r <= IDX_W'(rd_sym_r);
    out_code_bits_r    <= rev_code;
    out_code_len_r     <= rd_len_r;
    out_end_of_table_r <= rd_last_r;
  end

  assign out_strobe       = out_strobe_r;
  assign out_symbol_index = out_symbol_index_r;
  assign out_code_bits    = out_code_bits_r;
  assign out_code_len     = out_code_len_r;
  assign out_end_of_table = out_end_of_table_r;

endmodule

`default_nettype wire

FILE: rtl/core/canonical_huffman_code_assign.sv
// Top level of the canonical Huffman code assignment block.
// Joins chc_ctrl and chc_dpath; depends on chc_pkg.
//
// Lengths load one word per cycle while busy is low (start high). The word
// marked last, or the one that fills the store, starts the first-code
// calculation (one length per cycle through a single adder), then the
// emit phase: one result per loaded symbol per cycle, read from the
// length store and registered in rd_len_r, then in the output registers.
// A drain state follows. Results are strobed for exactly one cycle on
// out_strobe and cannot be stalled; busy stays high until the last result
// is in flight.
`default_nettype none

module canonical_huffman_code_assign #(
  parameter int ALPHABET_SIZE = chc_pkg::ALPHABET_SIZE_DEF,
  parameter int MAX_LENGTHS   = chc_pkg::MAX_LENGTHS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [chc_pkg::LEN_W-1:0]       in_code_length,
  input  wire logic                            in_last_symbol,
  output logic                                 out_strobe,
  output logic [chc_pkg::IDX_W-1:0]            out_symbol_index,
  output logic [chc_pkg::CODE_OUT_W-1:0]       out_code_bits,
  output logic [chc_pkg::LEN_W-1:0]            out_code_len,
  output logic                                 out_end_of_table
);
  import chc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  chc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  chc_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_LENGTHS   (MAX_LENGTHS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_code_length   (in_code_length),
    .in_last_symbol   (in_last_symbol),
    .out_strobe       (out_strobe),
    .out_symbol_index (out_symbol_index),
    .out_code_bits    (out_code_bits),
    .out_code_len     (out_code_len),
    .out_end_of_table (out_end_of_table)
  );

endmodule

`default_nettype wire
